>>> rtl/brlt_pkg.sv
package brlt_pkg;

    localparam int ID_W        = 16;
    localparam int POS_W       = 63;
    localparam int DEF_ENTRIES = 8;
    localparam int DEF_FILE_W  = 16;
    localparam int DEF_OWNER_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // operation codes
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_SETW   = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // lock kinds
    localparam logic [1:0] KIND_UNLOCK = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    // origin codes
    localparam logic [1:0] ORG_START = 2'd0;
    localparam logic [1:0] ORG_CUR   = 2'd1;
    localparam logic [1:0] ORG_END   = 2'd2;
    localparam logic [1:0] ORG_BAD   = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_BADACC  = 3'd2,
        ST_BLOCK   = 3'd3,
        ST_SUSPEND = 3'd4,
        ST_NOENT   = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [1:0]       lock_kind;
        logic [ID_W-1:0]  file_id;
        logic [ID_W-1:0]  owner_id;
        logic [1:0]       origin_sel;
        logic [63:0]      start_offset;
        logic [63:0]      range_length;
        logic [POS_W-1:0] current_position;
        logic [POS_W-1:0] file_size;
        logic             file_lockable;
        logic             may_read;
        logic             may_write;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic             conflict_found;
        logic [1:0]       conflict_kind;
        logic [ID_W-1:0]  conflict_owner;
        logic [POS_W-1:0] conflict_first;
        logic [POS_W-1:0] conflict_length;
        logic             wake_waiters;
    } t_resp;

    // classified request handed from front to back
    typedef struct packed {
        logic             has_err;
        t_status          err_st;
        logic [1:0]       op;
        logic [1:0]       kind;
        logic [ID_W-1:0]  file;
        logic [ID_W-1:0]  owner;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
    } t_job;

endpackage

>>> rtl/brlt_front.sv
module brlt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  brlt_pkg::t_req i_req,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output brlt_pkg::t_job o_job
);
    import brlt_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_FIRST, F_LAST, F_PUSH} t_fstate;

    t_fstate          r_state;
    t_req             r_req;
    t_job             r_job;

    logic             is_get;
    logic             pre_inv;
    logic             bad_acc;
    logic [POS_W-1:0] base;
    logic [64:0]      sum_first;
    logic [63:0]      sum_last;

    // request checks, start position and last byte
    always_comb begin
        is_get  = (r_req.operation == OP_GET);
        pre_inv = (r_req.operation == OP_BAD) || (r_req.lock_kind == KIND_BAD) ||
                  (is_get && r_req.lock_kind == KIND_UNLOCK) || !r_req.file_lockable;
        bad_acc = !is_get &&
                  ((r_req.lock_kind == KIND_READ && !r_req.may_read) ||
                   (r_req.lock_kind == KIND_WRITE && !r_req.may_write));
        case (r_req.origin_sel)
            ORG_CUR: base = r_req.current_position;
            ORG_END: base = r_req.file_size;
            default: base = '0;
        endcase
        sum_first = {2'b00, base} + {r_req.start_offset[63], r_req.start_offset};
        sum_last  = {1'b0, r_job.first} + r_req.range_length - 64'd1;
    end

    assign o_req_ready = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= F_FIRST;
                    end
                end
                F_FIRST: begin
                    r_job.op      <= r_req.operation;
                    r_job.kind    <= r_req.lock_kind;
                    r_job.file    <= r_req.file_id;
                    r_job.owner   <= r_req.owner_id;
                    r_job.first   <= sum_first[POS_W-1:0];
                    r_job.last    <= POS_MAX;
                    if (pre_inv) begin
                        r_job.has_err <= 1'b1;
                        r_job.err_st  <= ST_INVALID;
                    end else if (bad_acc) begin
                        r_job.has_err <= 1'b1;
                        r_job.err_st  <= ST_BADACC;
                    end else if (r_req.origin_sel == ORG_BAD || sum_first[64:63] != 2'b00) begin
                        r_job.has_err <= 1'b1;
                        r_job.err_st  <= ST_INVALID;
                    end else begin
                        r_job.has_err <= 1'b0;
                        r_job.err_st  <= ST_OK;
                    end
                    r_state <= F_LAST;
                end
                F_LAST: begin
                    if (!r_job.has_err && r_req.range_length != 64'd0) begin
                        if (r_req.range_length[63] || sum_last[63]) begin
                            r_job.has_err <= 1'b1;
                            r_job.err_st  <= ST_INVALID;
                        end else begin
                            r_job.last <= sum_last[POS_W-1:0];
                        end
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/brlt_queue.sv
module brlt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  brlt_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output brlt_pkg::t_job o_pop_job
);
    import brlt_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_job           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != (QAW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointer wrap
    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= bump(r_wptr);
            end
            if (pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/brlt_back.sv
module brlt_back #(
    parameter int LOCK_ENTRIES = brlt_pkg::DEF_ENTRIES,
    parameter int FILE_ID_BITS = brlt_pkg::DEF_FILE_W,
    parameter int OWNER_BITS   = brlt_pkg::DEF_OWNER_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  brlt_pkg::t_job  i_job,
    output logic            o_resp_valid,
    input  logic            i_resp_ready,
    output brlt_pkg::t_resp o_resp
);
    import brlt_pkg::*;

    localparam int IW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;

    typedef enum logic [2:0] {B_IDLE, B_READ, B_EVAL, B_SPLIT, B_STORE, B_DONE} t_bstate;

    // entry store: kind flags in flops, the rest in memory
    logic [1:0]              r_kind    [LOCK_ENTRIES];
    logic [OWNER_BITS-1:0]   mem_owner [LOCK_ENTRIES];
    logic [FILE_ID_BITS-1:0] mem_file  [LOCK_ENTRIES];
    logic [POS_W-1:0]        mem_first [LOCK_ENTRIES];
    logic [POS_W-1:0]        mem_last  [LOCK_ENTRIES];

    t_bstate                 r_state;
    t_job                    r_job;
    t_resp                   r_res;
    t_resp                   r_out;
    logic                    r_out_valid;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           r_empty;
    logic                    r_empty_vld;
    logic                    r_unlock;
    logic [IW-1:0]           r_split_idx;
    logic [POS_W-1:0]        r_sp_first;
    logic [POS_W-1:0]        r_sp_last;
    logic [OWNER_BITS-1:0]   r_rd_owner;
    logic [FILE_ID_BITS-1:0] r_rd_file;
    logic [POS_W-1:0]        r_rd_first;
    logic [POS_W-1:0]        r_rd_last;

    logic                    we;
    logic [IW-1:0]           wa;
    logic [OWNER_BITS-1:0]   wd_owner;
    logic [FILE_ID_BITS-1:0] wd_file;
    logic [POS_W-1:0]        wd_first;
    logic [POS_W-1:0]        wd_last;

    logic [OWNER_BITS-1:0]   job_owner;
    logic [FILE_ID_BITS-1:0] job_file;
    logic [1:0]              cur_kind;
    logic                    is_get;
    logic                    is_unlock;
    logic                    hit;
    logic                    cover_lo;
    logic                    cover_hi;
    logic                    at_end;
    logic                    slot_free;
    logic                    empty_now;
    logic                    unlock_now;
    logic                    free_any;
    logic [IW-1:0]           free_idx;
    logic [POS_W-1:0]        span;
    logic [POS_W:0]          span_len;

    // scan compare on the entry just read
    always_comb begin
        job_owner = OWNER_BITS'(r_job.owner);
        job_file  = FILE_ID_BITS'(r_job.file);
        cur_kind  = r_kind[r_idx];
        is_get    = (r_job.op == OP_GET);
        is_unlock = (r_job.kind == KIND_UNLOCK);
        hit = (cur_kind != KIND_UNLOCK) && (r_rd_file == job_file) &&
              !(r_job.last < r_rd_first || r_job.first > r_rd_last) &&
              !(r_job.kind == KIND_READ && cur_kind == KIND_READ) &&
              !(!is_unlock && r_rd_owner == job_owner);
        cover_lo   = (r_job.first <= r_rd_first);
        cover_hi   = (r_job.last >= r_rd_last);
        at_end     = (r_idx == IW'(LOCK_ENTRIES-1));
        slot_free  = (r_state == B_READ) && (cur_kind == KIND_UNLOCK);
        empty_now  = r_empty_vld || slot_free;
        unlock_now = r_unlock || (r_state == B_EVAL && hit && is_unlock);
        span       = r_rd_last - r_rd_first;
        span_len   = {1'b0, span} + 1'b1;
    end

    // first free entry for a split
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = LOCK_ENTRIES-1; k >= 0; k--) begin
            if (r_kind[k] == KIND_UNLOCK) begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    // memory write port
    always_comb begin
        we       = 1'b0;
        wa       = r_idx;
        wd_owner = r_rd_owner;
        wd_file  = r_rd_file;
        wd_first = r_rd_first;
        wd_last  = r_rd_last;
        case (r_state)
            B_EVAL: begin
                if (hit && is_unlock && !(cover_lo && cover_hi)) begin
                    if (cover_lo) begin
                        we       = 1'b1;
                        wd_first = r_job.last + 1'b1;
                    end else begin
                        we      = free_any || cover_hi;
                        wd_last = r_job.first - 1'b1;
                    end
                end
            end
            B_SPLIT: begin
                we       = 1'b1;
                wa       = r_split_idx;
                wd_first = r_sp_first;
                wd_last  = r_sp_last;
            end
            B_STORE: begin
                we       = 1'b1;
                wa       = r_empty;
                wd_owner = job_owner;
                wd_file  = job_file;
                wd_first = r_job.first;
                wd_last  = r_job.last;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_owner[wa] <= wd_owner;
            mem_file[wa]  <= wd_file;
            mem_first[wa] <= wd_first;
            mem_last[wa]  <= wd_last;
        end
        r_rd_owner <= mem_owner[r_idx];
        r_rd_file  <= mem_file[r_idx];
        r_rd_first <= mem_first[r_idx];
        r_rd_last  <= mem_last[r_idx];
    end

    assign o_job_ready  = (r_state == B_IDLE);
    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    // scan sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < LOCK_ENTRIES; k++) begin
                r_kind[k] <= KIND_UNLOCK;
            end
        end else begin
            if (r_out_valid && i_resp_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job       <= i_job;
                        r_res       <= '{status: i_job.err_st, default: '0};
                        r_idx       <= '0;
                        r_empty_vld <= 1'b0;
                        r_unlock    <= 1'b0;
                        r_state     <= i_job.has_err ? B_DONE : B_READ;
                    end
                end
                B_READ, B_EVAL, B_SPLIT: begin
                    if (r_state == B_READ && !slot_free) begin
                        r_state <= B_EVAL;
                    end else if (r_state == B_EVAL && hit && is_get) begin
                        r_res.status          <= ST_OK;
                        r_res.conflict_found  <= 1'b1;
                        r_res.conflict_kind   <= cur_kind;
                        r_res.conflict_owner  <= ID_W'(r_rd_owner);
                        r_res.conflict_first  <= r_rd_first;
                        r_res.conflict_length <= span_len[POS_W] ? POS_MAX
                                                                 : span_len[POS_W-1:0];
                        r_state               <= B_DONE;
                    end else if (r_state == B_EVAL && hit && !is_unlock) begin
                        r_res.status <= (r_job.op == OP_SETW) ? ST_SUSPEND : ST_BLOCK;
                        r_state      <= B_DONE;
                    end else if (r_state == B_EVAL && hit && !cover_lo && !cover_hi
                                 && !free_any) begin
                        r_res.status <= ST_NOENT;
                        r_state      <= B_DONE;
                    end else if (r_state == B_EVAL && hit && !cover_lo && !cover_hi) begin
                        // middle unlock: second half goes to a free entry
                        r_unlock            <= 1'b1;
                        r_kind[free_idx]    <= cur_kind;
                        r_split_idx         <= free_idx;
                        r_sp_first          <= r_job.last + 1'b1;
                        r_sp_last           <= r_rd_last;
                        r_state             <= B_SPLIT;
                    end else begin
                        if (r_state == B_EVAL && hit) begin
                            r_unlock <= 1'b1;
                            if (cover_lo && cover_hi) begin
                                r_kind[r_idx] <= KIND_UNLOCK;
                            end
                        end
                        if (slot_free && !r_empty_vld) begin
                            r_empty     <= r_idx;
                            r_empty_vld <= 1'b1;
                        end
                        if (!at_end) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= B_READ;
                        end else if (is_get || is_unlock) begin
                            r_res.status       <= ST_OK;
                            r_res.wake_waiters <= is_unlock && unlock_now;
                            r_state            <= B_DONE;
                        end else if (!empty_now) begin
                            r_res.status <= ST_NOENT;
                            r_state      <= B_DONE;
                        end else begin
                            r_state <= B_STORE;
                        end
                    end
                end
                B_STORE: begin
                    r_kind[r_empty] <= r_job.kind;
                    r_res.status    <= ST_OK;
                    r_state         <= B_DONE;
                end
                B_DONE: begin
                    if (!r_out_valid) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/byte_range_lock_table.sv
// channel   direction  handshake                   payload
// request   in         i_req_valid / o_req_ready   i_req   (brlt_pkg::t_req)
// response  out        o_resp_valid / i_resp_ready o_resp  (brlt_pkg::t_resp)
//
// front end takes one request at a time: latch, start position, last byte, queue push
// back end: accept, read and evaluate each used entry, only read each free entry, split,
// store a new lock, post; one unlock can split up to LOCK_ENTRIES/2 entries
// a 2-deep queue between the two lets the front keep taking requests while the back scans
// a result waiting in the output register stalls the back end, and the front once the queue fills
// synchronous reset marks every entry unused at once, no clearing pass
module byte_range_lock_table #(
    parameter int LOCK_ENTRIES = brlt_pkg::DEF_ENTRIES,
    parameter int FILE_ID_BITS = brlt_pkg::DEF_FILE_W,
    parameter int OWNER_BITS   = brlt_pkg::DEF_OWNER_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  brlt_pkg::t_req  i_req,
    output logic            o_resp_valid,
    input  logic            i_resp_ready,
    output brlt_pkg::t_resp o_resp
);
    import brlt_pkg::*;

    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    // request checking and range computation
    brlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    // decoupling queue
    brlt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_job   (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_job    (qb_job)
    );

    // table scan and update
    brlt_back #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .FILE_ID_BITS (FILE_ID_BITS),
        .OWNER_BITS   (OWNER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (qb_valid),
        .o_job_ready  (qb_ready),
        .i_job        (qb_job),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp)
    );

endmodule
